// ===== sv/sample_summary_statistics_macros.svh =====
// Assertion macros shared by the sample summary statistics modules.
`ifndef SAMPLE_SUMMARY_STATISTICS_MACROS_SVH
`define SAMPLE_SUMMARY_STATISTICS_MACROS_SVH

// Same-cycle implication, checked on clk, disabled while rst is high.
`define SSS_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("sss assertion failed");

// Next-cycle implication, checked on clk, disabled while rst is high.
`define SSS_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("sss assertion failed");

`endif

// ===== sv/sss_pkg.sv =====
// Shared constants, types and controller states for the sample summary statistics block.
package sss_pkg;

  localparam int unsigned SAMPLE_W  = 16;
  localparam int unsigned COUNT_W   = 17;
  localparam int unsigned SUM_W     = 32;
  localparam int unsigned SQ_W      = 47;
  localparam int unsigned SQ_SPLIT  = 24;
  localparam int unsigned MEAN_W    = 16;
  localparam int unsigned VAR_W     = 31;
  localparam int unsigned DVD_W     = 64;
  localparam int unsigned DSR_W     = 33;
  localparam int unsigned MAX_COUNT = 65536;

  localparam logic signed [SAMPLE_W-1:0] SAMPLE_MAX = {1'b0, {(SAMPLE_W-1){1'b1}}};
  localparam logic signed [SAMPLE_W-1:0] SAMPLE_MIN = {1'b1, {(SAMPLE_W-1){1'b0}}};

  typedef enum logic [3:0] {
    S_ACCUM,
    S_MUL_LO,
    S_MUL_HI,
    S_DIFF,
    S_MEAN_GO,
    S_MEAN_RUN,
    S_VAR_GO,
    S_VAR_RUN,
    S_EMIT
  } sss_state_t;

  // Controller to datapath commands
  typedef struct packed {
    logic take;        // input transfer this cycle
    logic mul_lo;      // n * sumsq low part, sum^2, n^2
    logic mul_hi;      // n * sumsq high part
    logic diff;        // variance numerator
    logic div_start;   // launch the divider
    logic div_sel_var; // divider operands: 1 variance, 0 mean
    logic latch_mean;
    logic latch_var;
    logic emit;        // load result register, clear run
  } dp_cmd_t;

  // Datapath to controller status
  typedef struct packed {
    logic div_done;
    logic out_free;
  } dp_stat_t;

endpackage

// ===== sv/sss_div.sv =====
// Restoring divider, 64-bit dividend by 33-bit divisor, one quotient bit per cycle.
`include "sample_summary_statistics_macros.svh"

module sss_div (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        start,
  input  logic [sss_pkg::DVD_W-1:0]   dividend,
  input  logic [sss_pkg::DSR_W-1:0]   divisor,
  output logic                        busy,
  output logic                        done,
  output logic [sss_pkg::VAR_W-1:0]   quotient
);

  logic [sss_pkg::DVD_W-1:0] quo;
  logic [sss_pkg::DSR_W-1:0] rem;
  logic [sss_pkg::DSR_W-1:0] dsr;
  logic [5:0]                cnt;
  logic [sss_pkg::DSR_W:0]   shifted;
  logic [sss_pkg::DSR_W+1:0] trial;

  // Trial subtract of the shifted partial remainder
  assign shifted = {rem, quo[sss_pkg::DVD_W-1]};
  assign trial   = {1'b0, shifted} - {2'b00, dsr};

  // Control: busy for one step per dividend bit, done pulses after the last one
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= busy && (cnt == '0);
      if (start) begin
        busy <= 1'b1;
        cnt  <= 6'(sss_pkg::DVD_W - 1);
      end else if (busy) begin
        if (cnt == '0) begin
          busy <= 1'b0;
        end
        cnt <= cnt - 6'd1;
      end
    end
  end

  // Datapath: quotient shifts in where the dividend shifts out
  always_ff @(posedge clk) begin
    if (start) begin
      quo <= dividend;
      rem <= '0;
      dsr <= divisor;
    end else if (busy) begin
      if (!trial[sss_pkg::DSR_W+1]) begin
        rem <= trial[sss_pkg::DSR_W-1:0];
        quo <= {quo[sss_pkg::DVD_W-2:0], 1'b1};
      end else begin
        rem <= shifted[sss_pkg::DSR_W-1:0];
        quo <= {quo[sss_pkg::DVD_W-2:0], 1'b0};
      end
    end
  end

  assign quotient = quo[sss_pkg::VAR_W-1:0];

  `SSS_ASSERT_NOW(a_no_restart, start, !busy)

endmodule

// ===== sv/sss_dp.sv =====
// Datapath: run accumulators, end-of-run products, divider and result register.
`include "sample_summary_statistics_macros.svh"

module sss_dp (
  input  logic                          clk,
  input  logic                          rst,
  input  sss_pkg::dp_cmd_t              cmd,
  output sss_pkg::dp_stat_t             stat,
  input  logic [sss_pkg::SAMPLE_W-1:0]  sample,
  output logic                          m_tvalid,
  input  logic                          m_tready,
  output logic [127:0]                  m_tdata,
  output logic                          m_tuser
);

  logic [sss_pkg::COUNT_W-1:0]        acc_count;
  logic [sss_pkg::SUM_W-1:0]          acc_sum;
  logic [sss_pkg::SQ_W-1:0]           acc_sq;
  logic signed [sss_pkg::SAMPLE_W-1:0] acc_min;
  logic signed [sss_pkg::SAMPLE_W-1:0] acc_max;
  logic                               acc_drop;

  logic signed [sss_pkg::SAMPLE_W-1:0] samp;
  logic signed [31:0]                  sq_s;
  logic [sss_pkg::SUM_W-1:0]           asum;

  logic [40:0]                 p_lo;
  logic [39:0]                 p_hi;
  logic [63:0]                 asq;
  logic [sss_pkg::DSR_W-1:0]   nsq;
  logic [63:0]                 num;

  logic [sss_pkg::DVD_W-1:0]   div_dividend;
  logic [sss_pkg::DSR_W-1:0]   div_divisor;
  logic                        div_busy;
  logic                        div_done;
  logic [sss_pkg::VAR_W-1:0]   div_quot;

  logic [sss_pkg::MEAN_W-1:0]  mean_r;
  logic [sss_pkg::VAR_W-1:0]   var_r;

  assign samp = signed'(sample);
  assign sq_s = samp * samp;
  assign asum = acc_sum[sss_pkg::SUM_W-1] ? (32'd0 - acc_sum) : acc_sum;

  // Run accumulators; a sample past the count limit only sets the drop flag
  always_ff @(posedge clk) begin
    if (rst || cmd.emit) begin
      acc_count <= '0;
      acc_sum   <= '0;
      acc_sq    <= '0;
      acc_min   <= sss_pkg::SAMPLE_MAX;
      acc_max   <= sss_pkg::SAMPLE_MIN;
      acc_drop  <= 1'b0;
    end else if (cmd.take) begin
      if (acc_count >= sss_pkg::COUNT_W'(sss_pkg::MAX_COUNT)) begin
        acc_drop <= 1'b1;
      end else begin
        acc_count <= acc_count + 17'd1;
        acc_sum   <= acc_sum + {{(sss_pkg::SUM_W-sss_pkg::SAMPLE_W){samp[sss_pkg::SAMPLE_W-1]}},
                                samp};
        acc_sq    <= acc_sq + {15'd0, sq_s};
        if (samp < acc_min) begin
          acc_min <= samp;
        end
        if (samp > acc_max) begin
          acc_max <= samp;
        end
      end
    end
  end

  // Variance numerator n*sumsq - sum^2, over three registered steps
  always_ff @(posedge clk) begin
    if (cmd.mul_lo) begin
      p_lo <= 41'(acc_count) * 41'(acc_sq[sss_pkg::SQ_SPLIT-1:0]);
      asq  <= 64'(asum) * 64'(asum);
      nsq  <= 33'(acc_count) * 33'(acc_count);
    end
    if (cmd.mul_hi) begin
      p_hi <= 40'(acc_count) * 40'(acc_sq[sss_pkg::SQ_W-1:sss_pkg::SQ_SPLIT]);
    end
    if (cmd.diff) begin
      num <= {p_hi, 24'd0} + {23'd0, p_lo} - asq;
    end
  end

  // Shared divider: |sum| / n for the mean, numerator / n^2 for the variance
  assign div_dividend = cmd.div_sel_var ? num : {32'd0, asum};
  assign div_divisor  = cmd.div_sel_var ? nsq : {16'd0, acc_count};

  sss_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (cmd.div_start),
    .dividend (div_dividend),
    .divisor  (div_divisor),
    .busy     (div_busy),
    .done     (div_done),
    .quotient (div_quot)
  );

  // Quotient capture; mean takes the sign of the sum
  always_ff @(posedge clk) begin
    if (cmd.latch_mean && div_done) begin
      mean_r <= acc_sum[sss_pkg::SUM_W-1] ? (16'd0 - div_quot[sss_pkg::MEAN_W-1:0])
                                          : div_quot[sss_pkg::MEAN_W-1:0];
    end
    if (cmd.latch_var && div_done) begin
      var_r <= div_quot;
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (cmd.emit) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      m_tdata <= {var_r, mean_r, acc_max, acc_min, acc_sum, acc_count};
      m_tuser <= acc_drop;
    end
  end

  assign stat.div_done = div_done;
  assign stat.out_free = !m_tvalid || m_tready;

  `SSS_ASSERT_NOW(a_count_limit, 1'b1, acc_count <= sss_pkg::COUNT_W'(sss_pkg::MAX_COUNT))
  `SSS_ASSERT_NOW(a_emit_free, cmd.emit, stat.out_free)
  `SSS_ASSERT_NOW(a_div_idle_on_take, cmd.take, !div_busy)

endmodule

// ===== sv/sss_ctrl.sv =====
// Controller: sequences accumulation and the end-of-run arithmetic.
`include "sample_summary_statistics_macros.svh"

module sss_ctrl (
  input  logic               clk,
  input  logic               rst,
  input  logic               s_tvalid,
  input  logic               s_tlast,
  output logic               s_tready,
  output sss_pkg::dp_cmd_t   cmd,
  input  sss_pkg::dp_stat_t  stat
);

  sss_pkg::sss_state_t state;
  sss_pkg::sss_state_t state_next;

  // State register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= sss_pkg::S_ACCUM;
    end else begin
      state <= state_next;
    end
  end

  // Next state
  always_comb begin
    state_next = state;
    unique case (state)
      sss_pkg::S_ACCUM: begin
        if (s_tvalid && s_tlast) begin
          state_next = sss_pkg::S_MUL_LO;
        end
      end
      sss_pkg::S_MUL_LO:   state_next = sss_pkg::S_MUL_HI;
      sss_pkg::S_MUL_HI:   state_next = sss_pkg::S_DIFF;
      sss_pkg::S_DIFF:     state_next = sss_pkg::S_MEAN_GO;
      sss_pkg::S_MEAN_GO:  state_next = sss_pkg::S_MEAN_RUN;
      sss_pkg::S_MEAN_RUN: begin
        if (stat.div_done) begin
          state_next = sss_pkg::S_VAR_GO;
        end
      end
      sss_pkg::S_VAR_GO:   state_next = sss_pkg::S_VAR_RUN;
      sss_pkg::S_VAR_RUN: begin
        if (stat.div_done) begin
          state_next = sss_pkg::S_EMIT;
        end
      end
      sss_pkg::S_EMIT: begin
        if (stat.out_free) begin
          state_next = sss_pkg::S_ACCUM;
        end
      end
      default:             state_next = sss_pkg::S_ACCUM;
    endcase
  end

  // Outputs
  always_comb begin
    cmd      = '0;
    s_tready = 1'b0;
    unique case (state)
      sss_pkg::S_ACCUM: begin
        s_tready = 1'b1;
        cmd.take = s_tvalid;
      end
      sss_pkg::S_MUL_LO:   cmd.mul_lo = 1'b1;
      sss_pkg::S_MUL_HI:   cmd.mul_hi = 1'b1;
      sss_pkg::S_DIFF:     cmd.diff = 1'b1;
      sss_pkg::S_MEAN_GO:  cmd.div_start = 1'b1;
      sss_pkg::S_MEAN_RUN: cmd.latch_mean = 1'b1;
      sss_pkg::S_VAR_GO: begin
        cmd.div_start   = 1'b1;
        cmd.div_sel_var = 1'b1;
      end
      sss_pkg::S_VAR_RUN: begin
        cmd.div_sel_var = 1'b1;
        cmd.latch_var   = 1'b1;
      end
      sss_pkg::S_EMIT:     cmd.emit = stat.out_free;
      default: begin
        cmd      = '0;
        s_tready = 1'b0;
      end
    endcase
  end

  `SSS_ASSERT_NEXT(a_last_starts_math, s_tvalid && s_tready && s_tlast, state == sss_pkg::S_MUL_LO)
  `SSS_ASSERT_NOW(a_busy_blocks_input, state != sss_pkg::S_ACCUM, !cmd.take)

endmodule

// ===== sv/sample_summary_statistics.sv =====
// Top level of the per-run sample statistics block: count, sum, min, max, mean, variance.
// Samples are taken one per cycle while a run is open. The transfer that carries tlast
// closes the run; the block then holds s_tready low while it works out the result:
// partial products for n*sumsq - sum^2 and n^2 in the MUL_LO, MUL_HI and DIFF states,
// then two passes (a start state, then a wait for done) through one shared bit-per-cycle
// restoring divider (mean, then variance), then the EMIT state loads the result register.
// That last state stretches for as long as the previous result still waits unaccepted.
// A finished result waits in the output register while the next run is already being
// accumulated. Samples beyond 65536 in one run are dropped and reported on m_tuser.
// Mean truncates toward zero, variance is floored to an unsigned integer (Q31.0).
module sample_summary_statistics (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         s_tvalid,
  output logic                         s_tready,
  input  logic [sss_pkg::SAMPLE_W-1:0] s_tdata,  // [15:0] sample
  input  logic                         s_tlast,  // last sample of the run
  output logic                         m_tvalid,
  input  logic                         m_tready,
  // [16:0] count, [48:17] total, [64:49] smallest, [80:65] largest,
  // [96:81] mean, [127:97] variance
  output logic [127:0]                 m_tdata,
  output logic                         m_tuser   // [0] overflowed
);

  sss_pkg::dp_cmd_t  cmd;
  sss_pkg::dp_stat_t stat;

  sss_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tlast  (s_tlast),
    .s_tready (s_tready),
    .cmd      (cmd),
    .stat     (stat)
  );

  sss_dp u_dp (
    .clk      (clk),
    .rst      (rst),
    .cmd      (cmd),
    .stat     (stat),
    .sample   (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
  );

endmodule

// ===== bench/sample_stats_checker.sv =====
// Scoreboard for the sample statistics block: predicts each run result and compares it.
`timescale 1ns / 1ps

module sample_stats_checker
  import sss_pkg::*;
(
  input  logic                clk,
  input  logic                rst,
  input  logic                s_tvalid,
  input  logic                s_tready,
  input  logic [SAMPLE_W-1:0] s_tdata,   // [15:0] sample
  input  logic                s_tlast,
  input  logic                m_tvalid,
  input  logic                m_tready,
  input  logic [127:0]        m_tdata,   // count, total, smallest, largest, mean, variance
  input  logic                m_tuser,   // [0] overflowed
  output int                  mismatches,
  output int                  awaiting,
  output int                  runs_checked
);

  typedef struct {
    logic [COUNT_W-1:0]         count;
    logic signed [SUM_W-1:0]    total;
    logic signed [SAMPLE_W-1:0] smallest;
    logic signed [SAMPLE_W-1:0] largest;
    logic signed [MEAN_W-1:0]   mean;
    logic [VAR_W-1:0]           variance;
    logic                       overflowed;
  } run_stats_t;

  // Accumulators of the open run
  logic [COUNT_W-1:0]         run_len;
  logic signed [SUM_W-1:0]    run_sum;
  logic [SQ_W-1:0]            run_sq;
  logic signed [SAMPLE_W-1:0] run_lo;
  logic signed [SAMPLE_W-1:0] run_hi;
  logic                       run_clipped;

  run_stats_t stats_due[$];
  int         fault_tally;
  int         checked_tally;

  // Closing figures of a run; mean truncates toward zero, variance is floored
  function automatic run_stats_t summarize_run(input logic [COUNT_W-1:0] n,
                                               input logic signed [SUM_W-1:0] sum,
                                               input logic [SQ_W-1:0] sq,
                                               input logic signed [SAMPLE_W-1:0] lo,
                                               input logic signed [SAMPLE_W-1:0] hi,
                                               input logic clipped);
    run_stats_t      r;
    longint          s;
    longint unsigned mag;
    longint unsigned spread;
    s            = sum;
    r.count      = n;
    r.total      = sum;
    r.smallest   = lo;
    r.largest    = hi;
    r.overflowed = clipped;
    r.mean       = '0;
    r.variance   = '0;
    if (n != 0) begin
      mag        = (s < 0) ? -s : s;
      spread     = longint'(n) * sq - mag * mag;
      r.mean     = MEAN_W'(s / longint'(n));
      r.variance = VAR_W'(spread / (longint'(n) * longint'(n)));
    end
    return r;
  endfunction

  task automatic check_field(input string name, input logic signed [63:0] want,
                             input logic signed [63:0] got);
    if (got !== want) begin
      $error("%s mismatch: expected %0d, got %0d", name, want, got);
      fault_tally++;
    end
  endtask

  always @(posedge clk) begin
    run_stats_t                 want;
    logic signed [SAMPLE_W-1:0] sample_v;
    if (rst) begin
      run_len       = '0;
      run_sum       = '0;
      run_sq        = '0;
      run_lo        = SAMPLE_MAX;
      run_hi        = SAMPLE_MIN;
      run_clipped   = 1'b0;
      fault_tally   = 0;
      checked_tally = 0;
      stats_due.delete();
    end else begin
      // result transfer: compare against the oldest closed run
      if (m_tvalid && m_tready) begin
        if (stats_due.size() == 0) begin
          $error("result transfer with no run pending: count %0d", m_tdata[16:0]);
          fault_tally++;
        end else begin
          want = stats_due.pop_front();
          check_field("count", want.count, m_tdata[16:0]);
          check_field("total", want.total, $signed(m_tdata[48:17]));
          check_field("smallest", want.smallest, $signed(m_tdata[64:49]));
          check_field("largest", want.largest, $signed(m_tdata[80:65]));
          check_field("mean", want.mean, $signed(m_tdata[96:81]));
          check_field("variance", want.variance, m_tdata[127:97]);
          check_field("overflowed", want.overflowed, m_tuser);
          checked_tally++;
        end
      end

      // sample transfer: accumulate unless the run is already full
      if (s_tvalid && s_tready) begin
        sample_v = $signed(s_tdata);
        if (run_len >= MAX_COUNT) begin
          run_clipped = 1'b1;
        end else begin
          run_len = run_len + 1'b1;
          run_sum = run_sum + sample_v;
          run_sq  = run_sq + SQ_W'(longint'(sample_v) * longint'(sample_v));
          if (sample_v < run_lo) run_lo = sample_v;
          if (sample_v > run_hi) run_hi = sample_v;
        end
        if (s_tlast) begin
          stats_due.push_back(summarize_run(run_len, run_sum, run_sq, run_lo, run_hi,
                                            run_clipped));
          run_len     = '0;
          run_sum     = '0;
          run_sq      = '0;
          run_lo      = SAMPLE_MAX;
          run_hi      = SAMPLE_MIN;
          run_clipped = 1'b0;
        end
      end
    end
    mismatches   <= fault_tally;
    awaiting     <= stats_due.size();
    runs_checked <= checked_tally;
  end

endmodule

// ===== bench/tb_sample_summary_statistics.sv =====
// Testbench top for the sample statistics block: clock, reset, sample and result traffic.
`timescale 1ns / 1ps

module tb_sample_summary_statistics;
  import sss_pkg::*;

  // no-transfer watchdog; well above the long result hold-off plus a run's compute time
  localparam int STALL_LIMIT   = 20000;
  localparam int HOLD_CYCLES   = 1500;
  localparam int HOLD_AFTER    = 14;
  localparam int RANDOM_TARGET = 530;
  localparam int DRAIN_CYCLES  = 160;

  typedef enum int unsigned {MIX_WIDE, MIX_NARROW, MIX_EDGE} sample_mix_t;

  logic                clk;
  logic                rst;
  logic                s_tvalid;
  logic                s_tready;
  logic [SAMPLE_W-1:0] s_tdata;   // [15:0] sample
  logic                s_tlast;
  logic                m_tvalid;
  logic                m_tready;
  logic [127:0]        m_tdata;   // [16:0] count .. [127:97] variance
  logic                m_tuser;   // [0] overflowed
  int                  mismatches;
  int                  awaiting;
  int                  runs_checked;
  int                  offered;
  int                  idle_cycles;

  sample_summary_statistics dut (.*);
  sample_stats_checker      checker_i (.*);

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  function automatic logic [SAMPLE_W-1:0] draw_sample(input sample_mix_t mix);
    logic [SAMPLE_W-1:0] v;
    case (mix)
      MIX_NARROW: v = SAMPLE_W'(int'($urandom_range(0, 127)) - 64);
      MIX_EDGE: begin
        case ($urandom_range(0, 3))
          0:       v = SAMPLE_MIN;
          1:       v = SAMPLE_MAX;
          2:       v = '0;
          default: v = '1;
        endcase
      end
      default: v = SAMPLE_W'($urandom);
    endcase
    return v;
  endfunction

  // One sample transfer, after an optional gap with tvalid low
  task automatic push_sample(input logic [SAMPLE_W-1:0] value, input logic tail,
                             input int gap);
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      s_tdata  <= SAMPLE_W'($urandom);
      repeat (gap) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= value;
    s_tlast  <= tail;
    offered++;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
  endtask

  // Result side: random stalls, stretches of none, and one long hold-off
  initial begin : result_sink
    int stall;
    int taken;
    taken = 0;
    m_tready <= 1'b0;
    @(posedge clk);
    while (rst) @(posedge clk);
    forever begin
      if (taken == HOLD_AFTER) stall = HOLD_CYCLES;
      else if ($urandom_range(0, 2) == 0) stall = 0;
      else stall = $urandom_range(0, 17);
      if (stall > 0) begin
        m_tready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      m_tready <= 1'b1;
      @(posedge clk);
      while (!m_tvalid) @(posedge clk);
      taken++;
    end
  end

  // Watchdog on cycles without any transfer
  initial begin : watchdog
    idle_cycles = 0;
    while (idle_cycles < STALL_LIMIT) begin
      @(posedge clk);
      if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) idle_cycles = 0;
      else idle_cycles++;
    end
    $display("sample_summary_statistics verification failed");
    $finish;
  end

  initial begin : stimulus
    int          k;
    int          run_len;
    int          random_sent;
    bit          busy;
    sample_mix_t mix;
    rst      <= 1'b1;
    s_tvalid <= 1'b0;
    s_tdata  <= '0;
    s_tlast  <= 1'b0;
    offered     = 0;
    random_sent = 0;
    repeat (9) @(posedge clk);
    rst <= 1'b0;

    // single-sample runs at the extremes and zero
    push_sample(SAMPLE_MAX, 1'b1, $urandom_range(0, 17));
    push_sample(SAMPLE_MIN, 1'b1, $urandom_range(0, 17));
    push_sample('0, 1'b1, $urandom_range(0, 17));
    // widest spread of two samples
    push_sample(SAMPLE_MIN, 1'b0, $urandom_range(0, 17));
    push_sample(SAMPLE_MAX, 1'b1, $urandom_range(0, 17));
    // negative means: -5/3 and -1/3 truncate toward zero
    push_sample(16'hFFFF, 1'b0, $urandom_range(0, 17));
    push_sample(16'hFFFE, 1'b0, $urandom_range(0, 17));
    push_sample(16'hFFFE, 1'b1, $urandom_range(0, 17));
    push_sample(16'hFFFF, 1'b0, $urandom_range(0, 17));
    push_sample(16'hFFFF, 1'b0, $urandom_range(0, 17));
    push_sample(16'h0001, 1'b1, $urandom_range(0, 17));
    // constant runs at both rails, zero variance
    for (k = 0; k < 4; k++) push_sample(SAMPLE_MAX, k == 3, $urandom_range(0, 17));
    for (k = 0; k < 4; k++) push_sample(SAMPLE_MIN, k == 3, $urandom_range(0, 17));
    // alternating bit patterns
    push_sample(16'h5555, 1'b0, $urandom_range(0, 17));
    push_sample(16'hAAAA, 1'b1, $urandom_range(0, 17));

    // random runs, mostly short, some with back-to-back samples
    while (random_sent < RANDOM_TARGET) begin
      run_len = ($urandom_range(0, 9) == 0) ? $urandom_range(13, 60) : $urandom_range(1, 12);
      mix     = sample_mix_t'($urandom_range(0, 2));
      busy    = ($urandom_range(0, 3) == 0);
      for (k = 0; k < run_len; k++) begin
        push_sample(draw_sample(($urandom_range(0, 4) == 0) ? MIX_EDGE : mix),
                    k == run_len - 1, busy ? 0 : $urandom_range(0, 17));
        random_sent++;
      end
    end
    s_tvalid <= 1'b0;

    // wait for the last result, then let the block settle
    @(posedge clk);
    while (awaiting != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("%0d runs checked from %0d samples: rail values, truncated negative means,",
             runs_checked, offered);
    $display("random short and long runs, and a long result hold-off that stalls the input");
    if (mismatches == 0 && awaiting == 0) begin
      $display("sample_summary_statistics verification clean");
    end else begin
      $display("sample_summary_statistics verification failed");
    end
    $finish;
  end

endmodule
